### rtl/mds_pkg.sv
// Shared types, constants and constant tables of the mip level downsampler.
`timescale 1ns / 1ps
package mds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LIN_BITS   = 16;

  localparam int CHAN_BITS  = 8;
  localparam int CFG_BITS   = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;
  localparam int POS_BITS   = CFG_BITS - 1;
  localparam int HALF_COLS  = MAX_WIDTH / 2;
  localparam int COL_BITS   = $clog2(HALF_COLS);
  localparam int WT_BITS    = POS_BITS;
  localparam int HSUM_BITS  = LIN_BITS + WT_BITS;
  localparam int NORM_BITS  = 2 * WT_BITS;
  localparam int VSUM_BITS  = LIN_BITS + NORM_BITS;
  localparam int NUM_BITS   = VSUM_BITS + 1;
  localparam int DIVS_BITS  = NORM_BITS + LIN_BITS - 1;
  localparam int CNT_BITS   = $clog2(LIN_BITS);
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SRGB   = 2'd2
  } reg_idx_t;

  typedef logic [LIN_BITS-1:0]  lin_t;
  typedef logic [HSUM_BITS-1:0] hsum_t;
  typedef logic [VSUM_BITS-1:0] vsum_t;
  typedef vsum_t [3:0]          vrow_t;
  typedef lin_t [255:0]         decode_lut_t;
  typedef lin_t [254:0]         thr_lut_t;

  typedef struct packed {
    logic               en;
    logic               slot;
    logic [WT_BITS-1:0] wt;
    logic               first;
  } htap_t;

  typedef struct packed {
    logic               en;
    logic               bank;
    logic [WT_BITS-1:0] wt;
    logic               first;
    logic               last;
  } vtap_t;

  typedef struct packed {
    hsum_t [3:0]         hsum;
    logic [COL_BITS-1:0] col;
    vtap_t [1:0]         vt;
    logic                last_pixel;
  } col_word_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] width;
    logic [CFG_BITS-1:0] height;
    logic                srgb;
    logic                restart;
  } front_cfg_t;

  typedef struct packed {
    logic                 srgb;
    logic                 both_even;
    logic [NORM_BITS-1:0] norm;
  } back_cfg_t;

  function automatic logic [CFG_BITS-1:0] clamp_size(input logic [CFG_BITS-1:0] v,
                                                     input logic [CFG_BITS-1:0] max);
    logic [CFG_BITS-1:0] r;
    if (v < CFG_BITS'(2)) r = CFG_BITS'(2);
    else if (v > max)     r = max;
    else                  r = v;
    return r;
  endfunction

  localparam logic [63:0] LIN_MAX64 = (64'd1 << LIN_BITS) - 64'd1;
  localparam logic [63:0] Q30       = 64'd1 << 30;

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] qpow5(input logic [63:0] y);
    logic [63:0] a;
    logic [63:0] b;
    a = qmul(y, y);
    b = qmul(a, a);
    return qmul(b, y);
  endfunction

  // Linear light of sRGB level h/510: a linear segment for h up to 20, else a fifth-root bisection in Q30.
  function automatic lin_t half_level_to_linear(input logic [9:0] h);
    logic [63:0] num;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] l;
    logic [63:0] r;
    if (h <= 10'd20) begin
      num = 64'd100 * 64'(h) * LIN_MAX64;
      r = (64'd2 * num + 64'd658920) / 64'd1317840;
    end else begin
      t = (((64'd1000 * 64'(h) + 64'd28050) << 30) + 64'd269025) / 64'd538050;
      t2 = qmul(t, t);
      lo = 64'd0;
      hi = Q30;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (qpow5(mid) <= t2) lo = mid;
        else hi = mid - 64'd1;
      end
      l = qmul(t2, lo);
      r = (l * LIN_MAX64 + (64'd1 << 29)) >> 30;
      if (r > LIN_MAX64) r = LIN_MAX64;
    end
    return r[LIN_BITS-1:0];
  endfunction

  function automatic decode_lut_t build_decode_lut();
    decode_lut_t d;
    for (int c = 0; c < 256; c++) d[c] = half_level_to_linear(10'(2 * c));
    return d;
  endfunction

  function automatic thr_lut_t build_thr_lut();
    thr_lut_t d;
    for (int c = 0; c < 255; c++) d[c] = half_level_to_linear(10'(2 * c + 1));
    return d;
  endfunction

  localparam decode_lut_t DECODE_LUT = build_decode_lut();
  localparam thr_lut_t    THR_LUT    = build_thr_lut();

endpackage

### rtl/mds_ifs.sv
// Stream interfaces for source pixel words and mip pixel words.
`timescale 1ns / 1ps
interface mds_pix_in_if;
  logic                          valid;
  logic                          ready;
  logic [mds_pkg::CHAN_BITS-1:0] in_red;
  logic [mds_pkg::CHAN_BITS-1:0] in_green;
  logic [mds_pkg::CHAN_BITS-1:0] in_blue;
  logic [mds_pkg::CHAN_BITS-1:0] in_alpha;
  modport source(output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink(input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface mds_pix_out_if;
  logic                          valid;
  logic                          ready;
  logic [mds_pkg::CHAN_BITS-1:0] out_red;
  logic [mds_pkg::CHAN_BITS-1:0] out_green;
  logic [mds_pkg::CHAN_BITS-1:0] out_blue;
  logic [mds_pkg::CHAN_BITS-1:0] out_alpha;
  logic                          last_pixel;
  modport source(output valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                 input ready);
  modport sink(input valid, out_red, out_green, out_blue, out_alpha, last_pixel,
               output ready);
endinterface

### rtl/mds_front.sv
// Front end: pixel intake, tap classification and horizontal accumulation.
`timescale 1ns / 1ps
module mds_front (
  input  logic                clk,
  input  logic                rst,
  input  mds_pkg::front_cfg_t cfg,
  mds_pix_in_if.sink          pix_in,
  output mds_pkg::col_word_t  push_word,
  output logic                push,
  input  logic                full
);

  localparam int PB = mds_pkg::POS_BITS;
  localparam int CB = mds_pkg::COL_BITS;
  localparam int WB = mds_pkg::WT_BITS;

  logic [PB-1:0] x;
  logic [PB-1:0] y;

  logic [mds_pkg::CFG_BITS-1:0] w_c;
  logic [mds_pkg::CFG_BITS-1:0] h_c;
  logic [WB-1:0] wn;
  logic [WB-1:0] hn;
  logic [CB-1:0] kx;
  logic [CB-1:0] ky;
  logic [mds_pkg::CFG_BITS-1:0] x_p1;
  logic [mds_pkg::CFG_BITS-1:0] y_p1;

  mds_pkg::htap_t [1:0] ht;
  mds_pkg::vtap_t [1:0] vt;
  logic                 done;
  logic [CB-1:0]        col;
  logic                 vhit;
  mds_pkg::lin_t [3:0]  lin;
  logic [mds_pkg::CHAN_BITS-1:0] pix [4];

  // Stage register between classification and accumulation.
  logic                 a_valid;
  mds_pkg::htap_t [1:0] a_ht;
  mds_pkg::vtap_t [1:0] a_vt;
  logic                 a_done;
  logic [CB-1:0]        a_col;
  logic                 a_last;
  mds_pkg::lin_t [3:0]  a_lin;

  mds_pkg::hsum_t acc [2][4];
  mds_pkg::hsum_t prod [2][4];
  mds_pkg::hsum_t new0 [4];
  mds_pkg::hsum_t new1 [4];
  logic a_consume;
  logic take;

  assign w_c  = mds_pkg::clamp_size(cfg.width, mds_pkg::CFG_BITS'(mds_pkg::MAX_WIDTH));
  assign h_c  = mds_pkg::clamp_size(cfg.height, mds_pkg::CFG_BITS'(mds_pkg::MAX_HEIGHT));
  assign wn   = w_c[mds_pkg::CFG_BITS-1:1];
  assign hn   = h_c[mds_pkg::CFG_BITS-1:1];
  assign kx   = x[PB-1:1];
  assign ky   = y[PB-1:1];
  assign x_p1 = {1'b0, x} + mds_pkg::CFG_BITS'(1);
  assign y_p1 = {1'b0, y} + mds_pkg::CFG_BITS'(1);

  assign pix[0] = pix_in.in_red;
  assign pix[1] = pix_in.in_green;
  assign pix[2] = pix_in.in_blue;
  assign pix[3] = pix_in.in_alpha;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (cfg.srgb && c < 3) lin[c] = mds_pkg::DECODE_LUT[pix[c]];
      else lin[c] = mds_pkg::lin_t'(pix[c]);
    end
  end

  // Horizontal taps. An odd-width row uses three taps per output column, so an even
  // pixel closes one column and opens the next.
  always_comb begin
    ht   = '0;
    done = 1'b0;
    col  = '0;
    if (!w_c[0]) begin
      ht[0].en    = 1'b1;
      ht[0].slot  = kx[0];
      ht[0].wt    = WB'(1);
      ht[0].first = ~x[0];
      done        = x[0];
      col         = kx;
    end else if (x[0]) begin
      ht[0].en    = 1'b1;
      ht[0].slot  = kx[0];
      ht[0].wt    = wn;
    end else begin
      if (kx != '0) begin
        ht[0].en   = 1'b1;
        ht[0].slot = ~kx[0];
        ht[0].wt   = {1'b0, kx};
        done       = 1'b1;
        col        = kx - CB'(1);
      end
      if ({1'b0, kx} < wn) begin
        ht[1].en    = 1'b1;
        ht[1].slot  = kx[0];
        ht[1].wt    = wn - {1'b0, kx};
        ht[1].first = 1'b1;
      end
    end
  end

  always_comb begin
    vt   = '0;
    vhit = 1'b0;
    if (!h_c[0]) begin
      vt[0].en    = 1'b1;
      vt[0].bank  = ky[0];
      vt[0].wt    = WB'(1);
      vt[0].first = ~y[0];
      vt[0].last  = y[0];
      vhit        = y[0] && ({1'b0, ky} == hn - WB'(1));
    end else if (y[0]) begin
      vt[0].en    = 1'b1;
      vt[0].bank  = ky[0];
      vt[0].wt    = hn;
    end else begin
      if (ky != '0) begin
        vt[0].en   = 1'b1;
        vt[0].bank = ~ky[0];
        vt[0].wt   = {1'b0, ky};
        vt[0].last = 1'b1;
        vhit       = ({1'b0, ky} == hn);
      end
      if ({1'b0, ky} < hn) begin
        vt[1].en    = 1'b1;
        vt[1].bank  = ky[0];
        vt[1].wt    = hn - {1'b0, ky};
        vt[1].first = 1'b1;
      end
    end
  end

  assign a_consume    = a_valid && (!a_done || !full);
  assign pix_in.ready = !a_valid || a_consume;
  assign take         = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      x       <= '0;
      y       <= '0;
    end else begin
      if (take) a_valid <= 1'b1;
      else if (a_consume) a_valid <= 1'b0;
      if (cfg.restart) begin
        x <= '0;
        y <= '0;
      end else if (take) begin
        if (x_p1 >= w_c) begin
          x <= '0;
          if (y_p1 >= h_c) y <= '0;
          else y <= y_p1[PB-1:0];
        end else begin
          x <= x_p1[PB-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_ht   <= ht;
      a_vt   <= vt;
      a_done <= done;
      a_col  <= col;
      a_last <= done && ({1'b0, col} == wn - WB'(1)) && vhit;
      a_lin  <= lin;
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int c = 0; c < 4; c++) prod[j][c] = a_ht[j].wt * a_lin[c];
    end
    for (int c = 0; c < 4; c++) begin
      new0[c] = a_ht[0].first ? prod[0][c] : acc[a_ht[0].slot][c] + prod[0][c];
      new1[c] = a_ht[1].first ? prod[1][c] : acc[a_ht[1].slot][c] + prod[1][c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        for (int c = 0; c < 4; c++) acc[s][c] <= '0;
      end
    end else if (a_consume) begin
      for (int c = 0; c < 4; c++) begin
        if (a_ht[0].en) acc[a_ht[0].slot][c] <= new0[c];
        if (a_ht[1].en) acc[a_ht[1].slot][c] <= new1[c];
      end
    end
  end

  assign push = a_valid && a_done && !full;

  always_comb begin
    for (int c = 0; c < 4; c++) push_word.hsum[c] = new0[c];
    push_word.col        = a_col;
    push_word.vt         = a_vt;
    push_word.last_pixel = a_last;
  end

endmodule

### rtl/mds_queue.sv
// Short queue of finished column words between the front and back ends.
`timescale 1ns / 1ps
module mds_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mds_pkg::col_word_t push_word,
  input  logic               pop,
  output mds_pkg::col_word_t head,
  output logic               full,
  output logic               empty
);

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);

  mds_pkg::col_word_t slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign full  = (count == (PTR_BITS + 1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_BITS'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_BITS'(1);
      if (push && !pop) count <= count + (PTR_BITS + 1)'(1);
      else if (pop && !push) count <= count - (PTR_BITS + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

endmodule

### rtl/mds_back.sv
// Back end: vertical row sums in memory, normalizing divide, sRGB encode, output.
`timescale 1ns / 1ps
module mds_back (
  input  logic               clk,
  input  logic               rst,
  input  mds_pkg::back_cfg_t cfg,
  input  mds_pkg::col_word_t head,
  input  logic               empty,
  output logic               pop,
  mds_pix_out_if.source      pix_out
);

  localparam int NB = mds_pkg::NUM_BITS;
  localparam int DB = mds_pkg::DIVS_BITS;
  localparam int LB = mds_pkg::LIN_BITS;
  localparam int CB = mds_pkg::COL_BITS;
  localparam int KB = mds_pkg::CNT_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_ENC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  mds_pkg::col_word_t item;
  mds_pkg::vrow_t bank0_mem [mds_pkg::HALF_COLS];
  mds_pkg::vrow_t bank1_mem [mds_pkg::HALF_COLS];
  mds_pkg::vrow_t rd0;
  mds_pkg::vrow_t rd1;
  mds_pkg::vrow_t val0;
  mds_pkg::vrow_t val1;
  mds_pkg::vrow_t wdata0;
  mds_pkg::vrow_t wdata1;
  logic we0;
  logic we1;

  logic [NB-1:0] num [4];
  logic [NB-1:0] num_init [4];
  logic [DB-1:0] dsr;
  logic [LB-1:0] quot [4];
  logic [KB-1:0] cnt;
  logic [7:0]    enc_n [3];
  logic [2:0]    enc_bit;
  logic          out_load;

  assign pop = (state == S_IDLE) && !empty;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      val0[c] = item.vt[0].first ? item.vt[0].wt * item.hsum[c]
              : (item.vt[0].bank ? rd1[c] : rd0[c]) + item.vt[0].wt * item.hsum[c];
      val1[c] = item.vt[1].first ? item.vt[1].wt * item.hsum[c]
              : (item.vt[1].bank ? rd1[c] : rd0[c]) + item.vt[1].wt * item.hsum[c];
      num_init[c] = {1'b0, val0[c]} + NB'(cfg.norm >> 1);
    end
  end

  // The two vertical taps of an odd axis always fall in different banks.
  always_comb begin
    we0    = (state == S_UPD) &&
             ((item.vt[0].en && !item.vt[0].bank) || (item.vt[1].en && !item.vt[1].bank));
    we1    = (state == S_UPD) &&
             ((item.vt[0].en && item.vt[0].bank) || (item.vt[1].en && item.vt[1].bank));
    wdata0 = (item.vt[0].en && !item.vt[0].bank) ? val0 : val1;
    wdata1 = (item.vt[0].en && item.vt[0].bank) ? val0 : val1;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd0 <= bank0_mem[head.col];
      rd1 <= bank1_mem[head.col];
    end
    if (we0) bank0_mem[item.col] <= wdata0;
    if (we1) bank1_mem[item.col] <= wdata1;
  end

  assign out_load = (state == S_OUT) && (!pix_out.valid || pix_out.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (!empty) state_next = S_UPD;
      S_UPD: begin
        if (!(item.vt[0].en && item.vt[0].last)) state_next = S_IDLE;
        else if (!cfg.both_even) state_next = S_DIV;
        else if (cfg.srgb) state_next = S_ENC;
        else state_next = S_OUT;
      end
      S_DIV: if (cnt == KB'(LB - 1)) state_next = cfg.srgb ? S_ENC : S_OUT;
      S_ENC: if (enc_bit == 3'd0) state_next = S_OUT;
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pix_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) pix_out.valid <= 1'b1;
      else if (pix_out.ready) pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item <= head;
    if (state == S_UPD) begin
      for (int c = 0; c < 4; c++) begin
        num[c]  <= num_init[c];
        quot[c] <= num_init[c][LB+1:2];
      end
      dsr     <= DB'(cfg.norm) << (LB - 1);
      cnt     <= '0;
      enc_bit <= 3'd7;
      for (int c = 0; c < 3; c++) enc_n[c] <= '0;
    end
    if (state == S_DIV) begin
      // Restoring division, one quotient bit per cycle for all channels.
      for (int c = 0; c < 4; c++) begin
        if (num[c] >= NB'(dsr)) begin
          num[c]  <= num[c] - NB'(dsr);
          quot[c] <= {quot[c][LB-2:0], 1'b1};
        end else begin
          quot[c] <= {quot[c][LB-2:0], 1'b0};
        end
      end
      dsr <= dsr >> 1;
      cnt <= cnt + KB'(1);
    end
    if (state == S_ENC) begin
      // Binary search over the monotone threshold list, one bit per cycle.
      for (int c = 0; c < 3; c++) begin
        if (mds_pkg::THR_LUT[(enc_n[c] | (8'd1 << enc_bit)) - 8'd1] <= quot[c])
          enc_n[c] <= enc_n[c] | (8'd1 << enc_bit);
      end
      enc_bit <= enc_bit - 3'd1;
    end
    if (out_load) begin
      pix_out.out_red    <= cfg.srgb ? enc_n[0] : quot[0][7:0];
      pix_out.out_green  <= cfg.srgb ? enc_n[1] : quot[1][7:0];
      pix_out.out_blue   <= cfg.srgb ? enc_n[2] : quot[2][7:0];
      pix_out.out_alpha  <= quot[3][7:0];
      pix_out.last_pixel <= item.last_pixel;
    end
  end

endmodule

### rtl/mipmap_downsample_rgba8_unit.sv
// Top level of the RGBA8 mip level downsampler with its register port.
`timescale 1ns / 1ps
// Source pixels enter in raster order on pix_in, one word per clock while ready
// is high, and the next mip level leaves in raster order on pix_out, with
// last_pixel marking the final word of the level. Even axes average pixel pairs;
// odd axes use the three-tap polyphase box filter, and the weighted sum is
// divided by the total weight with half rounding up. In sRGB mode red, green and
// blue are decoded to 16-bit linear light, filtered, then re-encoded; alpha stays
// linear. The front end takes one word per clock while the queue has room and
// folds it into the horizontal sums; every second source pixel closes an output
// column and places a column word in a four-entry queue. The back end reads the
// row sum memory as it pops a column word and writes it back in the update
// state; for a word that completes a mip pixel it then runs the restoring
// divider when either axis is odd and the sRGB encode search in sRGB mode, and
// loads the output register. With both axes even and linear color the block
// sustains one pixel per clock on rows that finish no output. Rows that finish
// output are bounded by the back end and by the output ready. A write to the
// width, height or sRGB register restarts the frame at the first pixel; the
// user must write registers only while the block is empty, and the block itself
// does not enforce this. The row sum memory needs no clearing after reset.
module mipmap_downsample_rgba8_unit (
  input  logic                            clk,
  input  logic                            rst,
  mds_pix_in_if.sink                      pix_in,
  mds_pix_out_if.source                   pix_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mds_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [mds_pkg::DATA_BITS-1:0]   pwdata,
  output logic [mds_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);

  localparam int FB = mds_pkg::CFG_BITS;

  logic [FB-1:0] source_width;
  logic [FB-1:0] source_height;
  logic          srgb_mode;
  logic [mds_pkg::NORM_BITS-1:0] norm;
  logic          wr_en;
  logic          restart;
  logic [FB-1:0] w_c;
  logic [FB-1:0] h_c;
  logic [mds_pkg::WT_BITS-1:0] sx;
  logic [mds_pkg::WT_BITS-1:0] sy;
  mds_pkg::reg_idx_t reg_idx;

  mds_pkg::front_cfg_t front_cfg;
  mds_pkg::back_cfg_t  back_cfg;
  mds_pkg::col_word_t  push_word;
  mds_pkg::col_word_t  head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = mds_pkg::reg_idx_t'(paddr[3:2]);
  assign restart = wr_en &&
                   (reg_idx == mds_pkg::REG_WIDTH || reg_idx == mds_pkg::REG_HEIGHT ||
                    reg_idx == mds_pkg::REG_SRGB);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= FB'(2);
      source_height <= FB'(2);
      srgb_mode     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        mds_pkg::REG_WIDTH:  source_width  <= pwdata[FB-1:0];
        mds_pkg::REG_HEIGHT: source_height <= pwdata[FB-1:0];
        mds_pkg::REG_SRGB:   srgb_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mds_pkg::REG_WIDTH:  prdata = mds_pkg::DATA_BITS'(source_width);
      mds_pkg::REG_HEIGHT: prdata = mds_pkg::DATA_BITS'(source_height);
      mds_pkg::REG_SRGB:   prdata = mds_pkg::DATA_BITS'(srgb_mode);
      default:             prdata = '0;
    endcase
  end

  // Total filter weight: 2 on an even axis, the axis length on an odd one.
  assign w_c = mds_pkg::clamp_size(source_width, FB'(mds_pkg::MAX_WIDTH));
  assign h_c = mds_pkg::clamp_size(source_height, FB'(mds_pkg::MAX_HEIGHT));
  assign sx  = w_c[0] ? w_c[mds_pkg::WT_BITS-1:0] : mds_pkg::WT_BITS'(2);
  assign sy  = h_c[0] ? h_c[mds_pkg::WT_BITS-1:0] : mds_pkg::WT_BITS'(2);

  always_ff @(posedge clk) begin
    norm <= sx * sy;
  end

  assign front_cfg.width   = source_width;
  assign front_cfg.height  = source_height;
  assign front_cfg.srgb    = srgb_mode;
  assign front_cfg.restart = restart;

  assign back_cfg.srgb      = srgb_mode;
  assign back_cfg.both_even = ~w_c[0] & ~h_c[0];
  assign back_cfg.norm      = norm;

  mds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (front_cfg),
    .pix_in    (pix_in),
    .push_word (push_word),
    .push      (push),
    .full      (full)
  );

  mds_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  mds_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (back_cfg),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .pix_out (pix_out)
  );

endmodule
